// ===== sv/hdlc_frame_receiver_core_defines.svh =====
// ---------------------------------------------------------------------------
// HDLC receiver assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef HDLC_FRAME_RECEIVER_CORE_DEFINES_SVH
`define HDLC_FRAME_RECEIVER_CORE_DEFINES_SVH

// Property that must hold in the same cycle as its condition.
`define HDLC_RX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property whose consequence is checked in the cycle after its condition.
`define HDLC_RX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/hdlc_rx_pkg.sv =====
// ---------------------------------------------------------------------------
// HDLC receiver package
// Byte codes, status codes, register indexes, result type and CRC helper.
// ---------------------------------------------------------------------------
package hdlc_rx_pkg;

    localparam logic [7:0]  FLAG_BYTE      = 8'h7E;
    localparam logic [7:0]  ESC_BYTE       = 8'h7D;
    localparam logic [7:0]  ESC_XOR        = 8'h20;

    localparam logic [15:0] CRC_POLY_RESET = 16'h8408;
    localparam logic [15:0] FCS_INIT_RESET = 16'hFFFF;
    localparam logic [7:0]  MIN_LEN_RESET  = 8'd6;

    localparam logic [1:0]  CFG_CRC_POLY   = 2'd0;
    localparam logic [1:0]  CFG_FCS_INIT   = 2'd1;
    localparam logic [1:0]  CFG_MIN_LEN    = 2'd2;

    localparam logic        KIND_DATA      = 1'b0;
    localparam logic        KIND_REPORT    = 1'b1;

    localparam logic [1:0]  STAT_OK        = 2'd0;
    localparam logic [1:0]  STAT_FCS_ERR   = 2'd1;
    localparam logic [1:0]  STAT_ESC_ERR   = 2'd2;
    localparam logic [1:0]  STAT_OVERFLOW  = 2'd3;

    localparam logic [8:0]  LEN_MAX        = 9'd511;

    typedef struct packed {
        logic [15:0] crc_poly;
        logic [15:0] fcs_init;
        logic [7:0]  min_frame_len;
    } cfg_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  data_byte;
        logic [1:0]  frame_status;
        logic [7:0]  frame_type;
        logic [7:0]  frame_seq;
        logic [8:0]  payload_len;
    } result_t;

    // Reflected CRC-16 over one byte, least significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [7:0]  b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ poly;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/hdlc_rx_in_stage.sv =====
// ---------------------------------------------------------------------------
// HDLC receiver input stage
// Registers one raw byte and hands it on when the deframer takes it.
// ---------------------------------------------------------------------------
module hdlc_rx_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       byte_valid,
    output logic [7:0] byte_data,
    input  logic       byte_take
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // The slot is free when empty or when its byte leaves in this cycle.
    assign in_ready   = !valid_reg || byte_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !byte_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

// ===== sv/hdlc_rx_deframer.sv =====
// ---------------------------------------------------------------------------
// HDLC receiver deframer
// Flag hunt, unescape, two-byte FCS delay, CRC and the result register.
// ---------------------------------------------------------------------------
`include "hdlc_frame_receiver_core_defines.svh"

module hdlc_rx_deframer
#(
    parameter int FRAME_BUFFER_LEN = 512
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hdlc_rx_pkg::cfg_t    cfg,
    input  logic                 byte_valid,
    input  logic [7:0]           byte_data,
    output logic                 byte_take,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hdlc_rx_pkg::result_t result
);

    localparam int CNT_W = $clog2(FRAME_BUFFER_LEN);
    localparam int CMP_W = (CNT_W + 1 > 10) ? CNT_W + 1 : 10;
    localparam logic [CMP_W-1:0] BUF_LEN = CMP_W'(FRAME_BUFFER_LEN);

    logic             hunting_reg, hunting_next;
    logic [CNT_W-1:0] raw_reg, raw_next;
    logic             esc_reg, esc_next;
    logic [CNT_W-1:0] unesc_reg, unesc_next;
    logic [7:0]       tail0_reg, tail0_next;
    logic [7:0]       tail1_reg, tail1_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       seq_reg, seq_next;

    logic                 out_valid_reg, out_valid_next;
    hdlc_rx_pkg::result_t res_reg;

    logic                 res_valid;
    hdlc_rx_pkg::result_t res;

    logic [CMP_W-1:0] raw_plus1;
    logic [CMP_W-1:0] fwd_full;
    logic [8:0]       fwd_len;
    logic             unesc_ge4;
    logic [7:0]       ubyte;
    logic             take_en;

    assign byte_take = byte_valid && (!out_valid_reg || out_ready);

    assign raw_plus1 = CMP_W'(raw_reg) + CMP_W'(1);
    assign unesc_ge4 = CMP_W'(unesc_reg) >= CMP_W'(4);
    assign fwd_full  = unesc_ge4 ? (CMP_W'(unesc_reg) - CMP_W'(4)) : '0;
    assign fwd_len   = (fwd_full > CMP_W'(hdlc_rx_pkg::LEN_MAX)) ? hdlc_rx_pkg::LEN_MAX
                                                                  : fwd_full[8:0];

    always_comb
    begin
        hunting_next = hunting_reg;
        raw_next     = raw_reg;
        esc_next     = esc_reg;
        unesc_next   = unesc_reg;
        tail0_next   = tail0_reg;
        tail1_next   = tail1_reg;
        crc_next     = crc_reg;
        type_next    = type_reg;
        seq_next     = seq_reg;
        res_valid    = 1'b0;
        res          = '0;
        take_en      = 1'b0;
        ubyte        = byte_data;

        if (byte_take)
        begin
            if (hunting_reg)
            begin
                if (byte_data == hdlc_rx_pkg::FLAG_BYTE)
                begin
                    hunting_next = 1'b0;
                    raw_next     = CNT_W'(1);
                    esc_next     = 1'b0;
                    unesc_next   = '0;
                    tail0_next   = '0;
                    tail1_next   = '0;
                    crc_next     = cfg.fcs_init;
                    type_next    = '0;
                    seq_next     = '0;
                end
            end
            else if (byte_data == hdlc_rx_pkg::FLAG_BYTE)
            begin
                // Closing flag: report unless the frame is short, or too small with no dangling escape.
                res.result_kind = hdlc_rx_pkg::KIND_REPORT;
                res.frame_type  = type_reg;
                res.frame_seq   = seq_reg;
                res.payload_len = fwd_len;
                if (raw_plus1 < CMP_W'(cfg.min_frame_len))
                begin
                    res_valid = 1'b0;
                end
                else if (esc_reg)
                begin
                    res_valid        = 1'b1;
                    res.frame_status = hdlc_rx_pkg::STAT_ESC_ERR;
                end
                else if (unesc_ge4)
                begin
                    res_valid        = 1'b1;
                    res.frame_status = ({tail1_reg, tail0_reg} == crc_reg)
                                       ? hdlc_rx_pkg::STAT_OK : hdlc_rx_pkg::STAT_FCS_ERR;
                end
                // The closing flag opens the next frame.
                hunting_next = 1'b0;
                raw_next     = CNT_W'(1);
                esc_next     = 1'b0;
                unesc_next   = '0;
                tail0_next   = '0;
                tail1_next   = '0;
                crc_next     = cfg.fcs_init;
                type_next    = '0;
                seq_next     = '0;
            end
            else if (raw_plus1 >= BUF_LEN)
            begin
                res_valid        = 1'b1;
                res.result_kind  = hdlc_rx_pkg::KIND_REPORT;
                res.frame_status = hdlc_rx_pkg::STAT_OVERFLOW;
                res.frame_type   = type_reg;
                res.frame_seq    = seq_reg;
                res.payload_len  = fwd_len;
                hunting_next     = 1'b1;
                raw_next         = '0;
                esc_next         = 1'b0;
            end
            else
            begin
                raw_next = raw_plus1[CNT_W-1:0];
                if (esc_reg)
                begin
                    esc_next = 1'b0;
                    ubyte    = byte_data ^ hdlc_rx_pkg::ESC_XOR;
                    take_en  = 1'b1;
                end
                else if (byte_data == hdlc_rx_pkg::ESC_BYTE)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    take_en = 1'b1;
                end
            end

            if (take_en)
            begin
                if (unesc_reg == '0)
                begin
                    type_next = ubyte;
                end
                if (unesc_reg == CNT_W'(1))
                begin
                    seq_next = ubyte;
                end
                if (CMP_W'(unesc_reg) >= CMP_W'(2))
                begin
                    crc_next = hdlc_rx_pkg::crc_byte(crc_reg, tail0_reg, cfg.crc_poly);
                end
                if (unesc_ge4)
                begin
                    res_valid       = 1'b1;
                    res.result_kind = hdlc_rx_pkg::KIND_DATA;
                    res.data_byte   = tail0_reg;
                end
                tail0_next = tail1_reg;
                tail1_next = ubyte;
                unesc_next = unesc_reg + CNT_W'(1);
            end
        end
    end

    assign out_valid_next = (byte_take && res_valid) || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg   <= 1'b1;
            raw_reg       <= '0;
            esc_reg       <= 1'b0;
            unesc_reg     <= '0;
            tail0_reg     <= '0;
            tail1_reg     <= '0;
            crc_reg       <= hdlc_rx_pkg::FCS_INIT_RESET;
            type_reg      <= '0;
            seq_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hunting_reg   <= hunting_next;
            raw_reg       <= raw_next;
            esc_reg       <= esc_next;
            unesc_reg     <= unesc_next;
            tail0_reg     <= tail0_next;
            tail1_reg     <= tail1_next;
            crc_reg       <= crc_next;
            type_reg      <= type_next;
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_take && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    `HDLC_RX_ASSERT_NOW(a_hunt_raw_zero, hunting_reg, raw_reg == '0,
        "raw count not cleared while hunting")
    `HDLC_RX_ASSERT_NOW(a_unesc_le_raw, !hunting_reg, unesc_reg <= raw_reg,
        "more unescaped bytes than raw bytes")
    `HDLC_RX_ASSERT_NOW(a_data_fields_zero,
        out_valid_reg && res_reg.result_kind == hdlc_rx_pkg::KIND_DATA,
        res_reg.payload_len == '0 && res_reg.frame_status == hdlc_rx_pkg::STAT_OK,
        "payload result carries report fields")
    `HDLC_RX_ASSERT_NEXT(a_flag_restarts,
        byte_take && byte_data == hdlc_rx_pkg::FLAG_BYTE,
        !hunting_reg && raw_reg == CNT_W'(1) && unesc_reg == '0,
        "flag did not open a new frame")

endmodule

// ===== sv/hdlc_frame_receiver_core.sv =====
// ---------------------------------------------------------------------------
// HDLC frame receiver core
// Byte-stuffed HDLC deframer with CRC-16 frame check sequence verification.
// ---------------------------------------------------------------------------
// Usage:
// Raw line bytes enter on the input channel (in_valid, in_ready, rx_byte),
// one byte per transfer. Results leave on the output channel (out_valid,
// out_ready and the result fields). A result is either a payload byte
// (result_kind 0) or an end of frame report (result_kind 1) with type,
// sequence, payload length and status. Many bytes give no result at all.
// A transfer is registered in an input stage, and the deframer takes the
// byte from there once the output register is free or being emptied; its
// result, if any, is captured in the output register as the byte is taken.
// One byte is taken every cycle while the output is not stalled; the CRC
// update of one byte is combinational.
// While the output register holds a result that is not taken, processing
// stops and in_ready falls once the input stage is full, so nothing is lost.
// Reset clears the receiver to hunt for an opening flag and loads the
// register defaults (polynomial 0x8408, initial value 0xFFFF, minimum
// length 6). The cfg port writes one register per cycle with cfg_we high
// and should be used only while no frame data is in flight.
// ---------------------------------------------------------------------------
module hdlc_frame_receiver_core
#(
    parameter int FRAME_BUFFER_LEN = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [7:0]  data_byte,
    output logic [1:0]  frame_status,
    output logic [7:0]  frame_type,
    output logic [7:0]  frame_seq,
    output logic [8:0]  payload_len
);

    // Configuration registers; an index beyond the list is ignored.
    hdlc_rx_pkg::cfg_t    cfg_reg;
    hdlc_rx_pkg::cfg_t    cfg_next;

    logic                 byte_valid;
    logic [7:0]           byte_data;
    logic                 byte_take;
    hdlc_rx_pkg::result_t result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                hdlc_rx_pkg::CFG_CRC_POLY: cfg_next.crc_poly      = cfg_data;
                hdlc_rx_pkg::CFG_FCS_INIT: cfg_next.fcs_init      = cfg_data;
                hdlc_rx_pkg::CFG_MIN_LEN:  cfg_next.min_frame_len = cfg_data[7:0];
                default:                   cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_poly      <= hdlc_rx_pkg::CRC_POLY_RESET;
            cfg_reg.fcs_init      <= hdlc_rx_pkg::FCS_INIT_RESET;
            cfg_reg.min_frame_len <= hdlc_rx_pkg::MIN_LEN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Input register stage.
    hdlc_rx_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_take  (byte_take)
    );

    // Frame state machine, CRC and result register.
    hdlc_rx_deframer #(
        .FRAME_BUFFER_LEN (FRAME_BUFFER_LEN)
    ) u_deframer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_take  (byte_take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    assign result_kind  = result.result_kind;
    assign data_byte    = result.data_byte;
    assign frame_status = result.frame_status;
    assign frame_type   = result.frame_type;
    assign frame_seq    = result.frame_seq;
    assign payload_len  = result.payload_len;

endmodule

// ===== bench/tb_hdlc_frame_receiver_core.sv =====
// ---------------------------------------------------------------------------
// HDLC frame receiver core testbench
// Streams byte-stuffed HDLC frames through the receiver with random idling
// on both channels and checks every payload byte and frame report against
// a cycle-free behavioral predictor, across several register settings.
// ---------------------------------------------------------------------------
module tb_hdlc_frame_receiver_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_LEN       = 512;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_BYTES   = 150;

    // Clock, reset and block inputs, all known from time zero.
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [1:0]  cfg_index   = 2'd0;
    logic [15:0] cfg_data    = 16'd0;
    logic        in_valid    = 1'b0;
    logic [7:0]  rx_byte     = 8'd0;
    logic        out_ready   = 1'b0;

    logic        in_ready;
    logic        out_valid;
    logic        result_kind;
    logic [7:0]  data_byte;
    logic [1:0]  frame_status;
    logic [7:0]  frame_type;
    logic [7:0]  frame_seq;
    logic [8:0]  payload_len;

    // Line bytes waiting for the driver, and results the receiver still owes.
    logic [7:0]           line_bytes[$];
    hdlc_rx_pkg::result_t deframer_results[$];
    logic [7:0]           frame_body[$];

    // Copy of the register settings used by the predictor and the generator.
    logic [15:0] poly_cfg    = hdlc_rx_pkg::CRC_POLY_RESET;
    logic [15:0] init_cfg    = hdlc_rx_pkg::FCS_INIT_RESET;
    logic [7:0]  min_len_cfg = hdlc_rx_pkg::MIN_LEN_RESET;

    // Predicted receiver state.
    bit          rx_hunting  = 1'b1;
    int unsigned rx_raw_len  = 0;
    bit          rx_esc      = 1'b0;
    int unsigned rx_count    = 0;
    logic [7:0]  rx_tail[2]  = '{8'h00, 8'h00};
    logic [15:0] rx_crc      = hdlc_rx_pkg::FCS_INIT_RESET;
    logic [7:0]  rx_type     = 8'h00;
    logic [7:0]  rx_seq      = 8'h00;

    // Bookkeeping.
    bit          steady      = 1'b0;
    bit          byte_taken  = 1'b0;
    bit          line_hunting = 1'b1;
    int          bytes_queued = 0;
    int          bytes_taken  = 0;
    int          cycle_count  = 0;
    int          error_count  = 0;
    int          payload_seen = 0;
    int          reports_seen[4] = '{0, 0, 0, 0};
    hdlc_rx_pkg::result_t seen;
    hdlc_rx_pkg::result_t want;

    hdlc_frame_receiver_core
    #(
        .FRAME_BUFFER_LEN(BUF_LEN)
    )
    uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result_kind(result_kind),
        .data_byte(data_byte),
        .frame_status(frame_status),
        .frame_type(frame_type),
        .frame_seq(frame_seq),
        .payload_len(payload_len)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    // One byte of the reflected CRC-16, least significant bit first.
    function automatic logic [15:0] fcs_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] acc;
        acc = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            acc = acc[0] ? ((acc >> 1) ^ poly_cfg) : (acc >> 1);
        end
        return acc;
    endfunction

    // A flag opens a frame: everything is cleared and the flag itself
    // counts as the first raw byte.
    function void open_frame();
        rx_hunting = 1'b0;
        rx_raw_len = 1;
        rx_esc     = 1'b0;
        rx_count   = 0;
        rx_tail[0] = 8'h00;
        rx_tail[1] = 8'h00;
        rx_crc     = init_cfg;
        rx_type    = 8'h00;
        rx_seq     = 8'h00;
    endfunction

    // End of frame report. The payload count excludes the header and the
    // two FCS bytes still held in the delay line, and saturates.
    function void push_report(input logic [1:0] status);
        hdlc_rx_pkg::result_t r;
        int unsigned fwd;
        fwd = (rx_count >= 4) ? rx_count - 4 : 0;
        if (fwd > hdlc_rx_pkg::LEN_MAX)
        begin
            fwd = hdlc_rx_pkg::LEN_MAX;
        end
        r.result_kind  = hdlc_rx_pkg::KIND_REPORT;
        r.data_byte    = 8'h00;
        r.frame_status = status;
        r.frame_type   = rx_type;
        r.frame_seq    = rx_seq;
        r.payload_len  = fwd[8:0];
        deframer_results.push_back(r);
    endfunction

    // An unescaped byte enters the two-byte delay line. The byte that
    // leaves it is folded into the CRC and, past the header, forwarded.
    function void shift_in(input logic [7:0] c);
        hdlc_rx_pkg::result_t r;
        if (rx_count == 0)
        begin
            rx_type = c;
        end
        else if (rx_count == 1)
        begin
            rx_seq = c;
        end
        if (rx_count >= 2)
        begin
            rx_crc = fcs_update(rx_crc, rx_tail[0]);
            if (rx_count >= 4)
            begin
                r.result_kind  = hdlc_rx_pkg::KIND_DATA;
                r.data_byte    = rx_tail[0];
                r.frame_status = hdlc_rx_pkg::STAT_OK;
                r.frame_type   = 8'h00;
                r.frame_seq    = 8'h00;
                r.payload_len  = 9'd0;
                deframer_results.push_back(r);
            end
        end
        rx_tail[0] = rx_tail[1];
        rx_tail[1] = c;
        if (rx_count < 32'hFFFF)
        begin
            rx_count++;
        end
    endfunction

    // Works out what one accepted line byte makes the receiver emit.
    function void deframe_byte(input logic [7:0] b);
        if (rx_hunting)
        begin
            if (b == hdlc_rx_pkg::FLAG_BYTE)
            begin
                open_frame();
            end
        end
        else if (b == hdlc_rx_pkg::FLAG_BYTE)
        begin
            // Short frames are dropped first, then a dangling escape is
            // reported, then frames without a full header and FCS vanish.
            if (rx_raw_len + 1 < min_len_cfg)
            begin
            end
            else if (rx_esc)
            begin
                push_report(hdlc_rx_pkg::STAT_ESC_ERR);
            end
            else if (rx_count >= 4)
            begin
                push_report(({rx_tail[1], rx_tail[0]} == rx_crc)
                            ? hdlc_rx_pkg::STAT_OK : hdlc_rx_pkg::STAT_FCS_ERR);
            end
            open_frame();
        end
        else if (rx_raw_len + 1 >= BUF_LEN)
        begin
            // The frame buffer would fill: abort and hunt for a new flag.
            push_report(hdlc_rx_pkg::STAT_OVERFLOW);
            rx_hunting = 1'b1;
            rx_raw_len = 0;
            rx_esc     = 1'b0;
        end
        else
        begin
            rx_raw_len++;
            if (rx_esc)
            begin
                rx_esc = 1'b0;
                shift_in(b ^ hdlc_rx_pkg::ESC_XOR);
            end
            else if (b == hdlc_rx_pkg::ESC_BYTE)
            begin
                rx_esc = 1'b1;
            end
            else
            begin
                shift_in(b);
            end
        end
    endfunction

    // -----------------------------------------------------------------------
    // Driver and output stall, both changing on the falling edge.
    // -----------------------------------------------------------------------

    // A new byte is offered only once the previous one made its transfer,
    // so valid and the payload stay put while the receiver pushes back.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || byte_taken)
        begin
            if (line_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= 9))
            begin
                in_valid <= 1'b1;
                rx_byte  <= line_bytes.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= steady || ($urandom_range(0, 99) >= 9);
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: transfers are seen at the rising edge. Results are checked
    // before the byte accepted on the same edge is predicted; the receiver
    // cannot answer a byte in the cycle it takes it.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        byte_taken = rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {result_kind, data_byte, frame_status, frame_type, frame_seq,
                    payload_len};
            if (seen.result_kind == hdlc_rx_pkg::KIND_REPORT)
            begin
                reports_seen[seen.frame_status]++;
            end
            else
            begin
                payload_seen++;
            end
            if (deframer_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                begin
                    $display("ERROR: unexpected result kind %0d data %02h status %0d",
                             seen.result_kind, seen.data_byte, seen.frame_status);
                end
            end
            else
            begin
                want = deframer_results.pop_front();
                if (seen.result_kind !== want.result_kind ||
                    seen.data_byte !== want.data_byte ||
                    seen.frame_status !== want.frame_status ||
                    seen.frame_type !== want.frame_type ||
                    seen.frame_seq !== want.frame_seq ||
                    seen.payload_len !== want.payload_len)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("ERROR: expected kind %0d data %02h status %0d type %02h seq %02h len %0d",
                                 want.result_kind, want.data_byte, want.frame_status,
                                 want.frame_type, want.frame_seq, want.payload_len);
                        $display("       got      kind %0d data %02h status %0d type %02h seq %02h len %0d",
                                 seen.result_kind, seen.data_byte, seen.frame_status,
                                 seen.frame_type, seen.frame_seq, seen.payload_len);
                    end
                end
            end
        end
        if (byte_taken)
        begin
            bytes_taken++;
            deframe_byte(rx_byte);
        end
    end

    // Watchdog on the cycle counter.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("ERROR: timeout after %0d cycles", cycle_count);
        $display("hdlc_frame_receiver_core regression: fail");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Stimulus generation
    // -----------------------------------------------------------------------

    task automatic queue_line_byte(input logic [7:0] b);
        line_bytes.push_back(b);
        bytes_queued++;
    endtask

    // Stuffs one byte onto the line. Flag and escape codes must be escaped;
    // any other byte may be escaped too, except the one that would turn
    // into a flag on the wire.
    task automatic push_stuffed(input logic [7:0] b, input bit allow_extra);
        if (b == hdlc_rx_pkg::FLAG_BYTE || b == hdlc_rx_pkg::ESC_BYTE ||
            (allow_extra && b != (hdlc_rx_pkg::FLAG_BYTE ^ hdlc_rx_pkg::ESC_XOR) &&
             $urandom_range(0, 9) == 0))
        begin
            queue_line_byte(hdlc_rx_pkg::ESC_BYTE);
            queue_line_byte(b ^ hdlc_rx_pkg::ESC_XOR);
        end
        else
        begin
            queue_line_byte(b);
        end
    endtask

    // One frame from header, frame_body and FCS, closed by a flag. The
    // opening flag is left to the caller, since frames may share flags.
    task automatic add_frame(input logic [7:0] ftype, input logic [7:0] fseq,
                             input bit bad_fcs, input bit esc_end,
                             input bit allow_extra);
        logic [15:0] fcs;
        fcs = fcs_update(init_cfg, ftype);
        fcs = fcs_update(fcs, fseq);
        foreach (frame_body[i])
        begin
            fcs = fcs_update(fcs, frame_body[i]);
        end
        if (bad_fcs)
        begin
            fcs = fcs ^ (16'h0001 << $urandom_range(0, 15));
        end
        push_stuffed(ftype, allow_extra);
        push_stuffed(fseq, allow_extra);
        foreach (frame_body[i])
        begin
            push_stuffed(frame_body[i], allow_extra);
        end
        push_stuffed(fcs[7:0], allow_extra);
        push_stuffed(fcs[15:8], allow_extra);
        if (esc_end)
        begin
            queue_line_byte(hdlc_rx_pkg::ESC_BYTE);
        end
        queue_line_byte(hdlc_rx_pkg::FLAG_BYTE);
    endtask

    // Payload bytes lean toward the flag and escape codes and their
    // escaped forms, so stuffing is exercised often.
    task automatic fill_body(input int len);
        logic [7:0] picks[4];
        picks = '{hdlc_rx_pkg::FLAG_BYTE, hdlc_rx_pkg::ESC_BYTE,
                  hdlc_rx_pkg::FLAG_BYTE ^ hdlc_rx_pkg::ESC_XOR,
                  hdlc_rx_pkg::ESC_BYTE ^ hdlc_rx_pkg::ESC_XOR};
        frame_body.delete();
        repeat (len)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                frame_body.push_back(picks[$urandom_range(0, 3)]);
            end
            else
            begin
                frame_body.push_back(8'($urandom()));
            end
        end
    endtask

    // Frames that run to the raw length limit. The clean one ends just at
    // the limit; the other overflows, and the bytes after it are ignored
    // while the receiver hunts.
    task automatic add_long(input bit overflow);
        logic [7:0] b;
        queue_line_byte(hdlc_rx_pkg::FLAG_BYTE);
        if (overflow)
        begin
            repeat (BUF_LEN + 6)
            begin
                b = 8'($urandom());
                queue_line_byte((b == hdlc_rx_pkg::FLAG_BYTE) ? 8'h00 : b);
            end
            line_hunting = 1'b1;
        end
        else
        begin
            frame_body.delete();
            repeat (BUF_LEN - 6)
            begin
                b = 8'($urandom());
                frame_body.push_back((b == hdlc_rx_pkg::FLAG_BYTE ||
                                      b == hdlc_rx_pkg::ESC_BYTE) ? ~b : b);
            end
            add_frame(8'h3C, 8'hC3, 1'b0, 1'b0, 1'b0);
        end
    endtask

    // Mostly good frames with random content; the rest carry a broken FCS,
    // a dangling escape, too few bytes, or plain line noise.
    task automatic add_random_frame();
        int pick;
        int k;
        pick = $urandom_range(0, 99);
        if (line_hunting || $urandom_range(0, 9) < 3)
        begin
            queue_line_byte(hdlc_rx_pkg::FLAG_BYTE);
            line_hunting = 1'b0;
        end
        if (pick < 77)
        begin
            fill_body(($urandom_range(0, 4) != 0) ? $urandom_range(0, 12)
                                                   : $urandom_range(13, 40));
            add_frame(8'($urandom()), 8'($urandom()), pick >= 62 && pick < 70,
                      pick >= 70, 1'b1);
        end
        else if (pick < 87)
        begin
            k = $urandom_range(0, 3);
            repeat (k)
            begin
                push_stuffed(8'($urandom()), 1'b1);
            end
            if ($urandom_range(0, 1) == 1)
            begin
                queue_line_byte(hdlc_rx_pkg::ESC_BYTE);
            end
            queue_line_byte(hdlc_rx_pkg::FLAG_BYTE);
        end
        else
        begin
            fill_body($urandom_range(1, 10));
            foreach (frame_body[i])
            begin
                queue_line_byte(frame_body[i]);
            end
            queue_line_byte(hdlc_rx_pkg::FLAG_BYTE);
        end
    endtask

    // Waits until the sender is empty and every owed result has made its
    // transfer, then lets bytes that produce nothing drain from the pipe.
    task automatic drain_receiver();
        while (line_bytes.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (deframer_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            hdlc_rx_pkg::CFG_CRC_POLY: poly_cfg    = value;
            hdlc_rx_pkg::CFG_FCS_INIT: init_cfg    = value;
            hdlc_rx_pkg::CFG_MIN_LEN:  min_len_cfg = value[7:0];
            default:                   ;
        endcase
    endtask

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial
    begin
        logic [15:0] poly;
        logic [15:0] init;
        logic [7:0]  min_len;
        int          budget;

        repeat (3)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part with the reset settings. Noise before the first
        // flag is ignored while hunting.
        queue_line_byte(8'h00);
        queue_line_byte(8'hFF);
        queue_line_byte(hdlc_rx_pkg::FLAG_BYTE);
        // Good frame with extreme header values and stuffed payload.
        frame_body = '{hdlc_rx_pkg::FLAG_BYTE, hdlc_rx_pkg::ESC_BYTE, 8'h00, 8'hFF};
        add_frame(8'h00, 8'hFF, 1'b0, 1'b0, 1'b0);
        // Header and FCS only, with a broken FCS.
        frame_body.delete();
        add_frame(8'hFF, 8'h00, 1'b1, 1'b0, 1'b0);
        // Closing flag right after an escape.
        frame_body = '{8'h5A};
        add_frame(8'h11, 8'h22, 1'b0, 1'b1, 1'b0);
        // Only three unescaped bytes: dropped without a report.
        queue_line_byte(8'h01);
        queue_line_byte(hdlc_rx_pkg::ESC_BYTE);
        queue_line_byte(8'h22);
        queue_line_byte(8'h03);
        queue_line_byte(hdlc_rx_pkg::FLAG_BYTE);
        // Back-to-back flags make a frame that is too short.
        queue_line_byte(hdlc_rx_pkg::FLAG_BYTE);
        drain_receiver();

        // Random phases, each under its own register settings. The first
        // frame of a phase always gets a fresh opening flag so that its CRC
        // starts from the new initial value.
        for (int phase = 1; phase <= 5; phase++)
        begin
            case (phase)
                1:
                begin
                    poly = hdlc_rx_pkg::CRC_POLY_RESET;
                    init = hdlc_rx_pkg::FCS_INIT_RESET;
                    min_len = 8'd4;
                end
                2:
                begin
                    poly = 16'h0000;
                    init = 16'h0000;
                    min_len = 8'd255;
                end
                3:
                begin
                    poly = 16'hFFFF;
                    init = 16'hFFFF;
                    min_len = hdlc_rx_pkg::MIN_LEN_RESET;
                end
                4:
                begin
                    poly = 16'($urandom());
                    init = 16'($urandom());
                    min_len = 8'($urandom_range(4, 32));
                end
                default:
                begin
                    poly = 16'($urandom());
                    init = 16'($urandom());
                    min_len = 8'd5;
                end
            endcase
            write_register(hdlc_rx_pkg::CFG_CRC_POLY, poly);
            write_register(hdlc_rx_pkg::CFG_FCS_INIT, init);
            write_register(hdlc_rx_pkg::CFG_MIN_LEN, {8'h00, min_len});
            @(negedge clk);
            cfg_we <= 1'b0;

            // Phase three runs with both sides streaming, no idle cycles.
            steady = (phase == 3);
            line_hunting = 1'b1;

            if (phase == 2)
            begin
                add_long(1'b0);
                add_long(1'b1);
            end
            if (phase == 4)
            begin
                // The sender stops in the middle of a frame until the
                // receiver has delivered everything, then finishes it.
                queue_line_byte(hdlc_rx_pkg::FLAG_BYTE);
                repeat (6)
                begin
                    push_stuffed(8'($urandom()), 1'b1);
                end
                drain_receiver();
                repeat (4)
                begin
                    push_stuffed(8'($urandom()), 1'b1);
                end
                queue_line_byte(hdlc_rx_pkg::FLAG_BYTE);
                line_hunting = 1'b0;
            end

            budget = bytes_queued + PHASE_BYTES;
            while (bytes_queued < budget)
            begin
                add_random_frame();
            end
            drain_receiver();
        end

        repeat (20)
        begin
            @(posedge clk);
        end
        if (deframer_results.size() != 0)
        begin
            error_count++;
            $display("ERROR: %0d results never arrived", deframer_results.size());
        end

        $display("Ran %0d line bytes in %0d cycles: %0d payload bytes forwarded.",
                 bytes_taken, cycle_count, payload_seen);
        $display("Frame reports: %0d ok, %0d FCS error, %0d escape error, %0d overflow.",
                 reports_seen[hdlc_rx_pkg::STAT_OK], reports_seen[hdlc_rx_pkg::STAT_FCS_ERR],
                 reports_seen[hdlc_rx_pkg::STAT_ESC_ERR],
                 reports_seen[hdlc_rx_pkg::STAT_OVERFLOW]);
        if (error_count == 0)
        begin
            $display("hdlc_frame_receiver_core regression: pass");
        end
        else
        begin
            $display("%0d errors", error_count);
            $display("hdlc_frame_receiver_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/hdlc_rx_pkg.sv
sv/hdlc_rx_in_stage.sv
sv/hdlc_rx_deframer.sv
sv/hdlc_frame_receiver_core.sv
bench/tb_hdlc_frame_receiver_core.sv
